// ===== hw/rtl/nearest_point_hit_test_macros.svh =====
// Assertion macros for the nearest point hit test block.
// Expects clk and rst_n in the scope of each use.
`ifndef NEAREST_POINT_HIT_TEST_MACROS_SVH
`define NEAREST_POINT_HIT_TEST_MACROS_SVH

// check cons in the same cycle as ante
`define NPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npht assertion failed");

// check cons in the cycle after ante
`define NPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npht assertion failed");

`endif

// ===== hw/rtl/npht_pkg.sv =====
// Types and codes for the nearest point hit test block.
// No dependencies.
package npht_pkg;

  localparam int COORD_W    = 15;
  localparam int TAG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HIT_IDX_W  = 10;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_OFFSCREEN = 3'd1,
    ST_FULL      = 3'd2,
    ST_MISS      = 3'd3,
    ST_HIT       = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [1:0]        point_kind;
    logic [TAG_W-1:0]  tag;
    logic [15:0]       tolerance;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [TAG_W-1:0]     hit_tag;
    logic [COORD_W-1:0]   hit_x;
    logic [COORD_W-1:0]   hit_y;
    logic                 hit_kind;
    logic [HIT_IDX_W-1:0] hit_index;
  } out_beat_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               kind;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

endpackage

// ===== hw/rtl/nearest_point_hit_test.sv =====
// Nearest point hit test: point table, add/clear, nearest query within a radius.
// Depends on npht_pkg and nearest_point_hit_test_macros.svh.
//
//   channel | ports                          | direction
//   in      | in_valid  in_ready  in_data    | command beat in
//   out     | out_valid out_ready out_data   | one result beat per command
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write, always ready
//
// Clear, add and unused codes: from accept to the result state, then into the output register.
// Query: the tolerance is squared in the limit state; then the table's single read
// port feeds a five-stage distance pipe one entry per cycle, then the pipe drains.
// Reset is synchronous, clears the entry count and x_max/y_max; no memory sweep.
// A result waits in the output register while the next command is taken;
// the block stalls in its result state only if that register is still full.
`include "nearest_point_hit_test_macros.svh"

module nearest_point_hit_test #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  npht_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output npht_pkg::out_beat_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [npht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import npht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] x_max_r, y_max_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      rd_addr_r;

  logic signed [15:0] q_x_r, q_y_r;
  logic               q_kind_r, q_either_r, is_query_r;
  logic [15:0]        q_tol_r;
  status_t            res_status_r;
  logic [31:0]        limit_r;

  logic               v1_r, v2_r, v3_r, v4_r;
  entry_t             ent1_r, ent2_r, ent3_r, ent4_r;
  logic [AW-1:0]      idx1_r, idx2_r, idx3_r, idx4_r;
  logic [15:0]        abs_x2_r, abs_y2_r;
  logic [31:0]        sq_x3_r, sq_y3_r;
  logic [32:0]        dist4_r;

  logic               found_r;
  logic [32:0]        best_dist_r;
  entry_t             best_ent_r;
  logic [AW-1:0]      best_idx_r;

  logic               out_valid_r;
  out_beat_t          out_r, out_nxt;

  logic               in_fire, issue, offscreen, wr_en, load_out, hit_upd;
  logic signed [16:0] dx, dy;
  logic [15:0]        sq_in_a;
  logic [31:0]        sq_a, sq_b;
  entry_t             wr_ent;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_fire   = in_valid && in_ready;
  assign issue     = (state_r == S_SCAN) && (rd_addr_r != count_r);
  assign offscreen = in_data.x_coord[15] || in_data.y_coord[15] ||
                     (in_data.x_coord[COORD_W-1:0] > x_max_r) ||
                     (in_data.y_coord[COORD_W-1:0] > y_max_r);
  assign wr_en     = in_fire && (in_data.operation == OP_ADD) && !offscreen &&
                     (count_r != DEPTH_C);
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_ready);

  assign wr_ent.tag  = in_data.tag;
  assign wr_ent.kind = in_data.point_kind[0];
  assign wr_ent.y    = in_data.y_coord[COORD_W-1:0];
  assign wr_ent.x    = in_data.x_coord[COORD_W-1:0];

  assign dx      = $signed({2'b00, ent1_r.x}) - $signed({q_x_r[15], q_x_r});
  assign dy      = $signed({2'b00, ent1_r.y}) - $signed({q_y_r[15], q_y_r});
  assign sq_in_a = (state_r == S_LIMIT) ? q_tol_r : abs_x2_r;
  assign sq_a    = sq_in_a * sq_in_a;
  assign sq_b    = abs_y2_r * abs_y2_r;
  assign hit_upd = v4_r && (dist4_r < {1'b0, limit_r}) &&
                   (!found_r || (dist4_r < best_dist_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.operation == OP_QUERY) ? S_LIMIT : S_RESP;
        end
      end
      S_LIMIT: state_nxt = S_SCAN;
      S_SCAN: begin
        if (rd_addr_r == count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(v1_r || v2_r || v3_r || v4_r)) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_max_r <= '0;
      y_max_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_MAX: x_max_r <= cfg_data[COORD_W-1:0];
        REG_Y_MAX: y_max_r <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode and table bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      is_query_r <= 1'b0;
    end else if (in_fire) begin
      is_query_r   <= 1'b0;
      res_status_r <= ST_DONE;
      unique case (op_t'(in_data.operation))
        OP_CLEAR: count_r <= '0;
        OP_ADD: begin
          if (offscreen) begin
            res_status_r <= ST_OFFSCREEN;
          end else if (count_r == DEPTH_C) begin
            res_status_r <= ST_FULL;
          end else begin
            count_r <= count_r + 1'b1;
          end
        end
        OP_QUERY: is_query_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_x_r      <= in_data.x_coord;
      q_y_r      <= in_data.y_coord;
      q_kind_r   <= in_data.point_kind[0];
      q_either_r <= in_data.point_kind[1];
      q_tol_r    <= in_data.tolerance;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_ent;
    end
    ent1_r <= mem[rd_addr_r[AW-1:0]];
  end

  // distance pipe: read, abs diff, square, sum, compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (state_r == S_LIMIT) begin
        rd_addr_r <= '0;
        found_r   <= 1'b0;
        limit_r   <= sq_a;
      end else if (issue) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      v1_r   <= issue;
      idx1_r <= rd_addr_r[AW-1:0];

      v2_r     <= v1_r && (q_either_r || (ent1_r.kind == q_kind_r));
      ent2_r   <= ent1_r;
      idx2_r   <= idx1_r;
      abs_x2_r <= dx[16] ? 16'(-dx) : dx[15:0];
      abs_y2_r <= dy[16] ? 16'(-dy) : dy[15:0];

      v3_r    <= v2_r;
      ent3_r  <= ent2_r;
      idx3_r  <= idx2_r;
      sq_x3_r <= sq_a;
      sq_y3_r <= sq_b;

      v4_r    <= v3_r;
      ent4_r  <= ent3_r;
      idx4_r  <= idx3_r;
      dist4_r <= {1'b0, sq_x3_r} + {1'b0, sq_y3_r};

      if (hit_upd) begin
        found_r     <= 1'b1;
        best_dist_r <= dist4_r;
        best_ent_r  <= ent4_r;
        best_idx_r  <= idx4_r;
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    if (!is_query_r) begin
      out_nxt.status = res_status_r;
    end else if (found_r) begin
      out_nxt.status    = ST_HIT;
      out_nxt.hit_tag   = best_ent_r.tag;
      out_nxt.hit_x     = best_ent_r.x;
      out_nxt.hit_y     = best_ent_r.y;
      out_nxt.hit_kind  = best_ent_r.kind;
      out_nxt.hit_index = HIT_IDX_W'(best_idx_r);
    end else begin
      out_nxt.status = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
      out_r       <= out_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  `NPHT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= DEPTH_C)
  `NPHT_ASSERT_NOW(a_scan_addr, state_r == S_SCAN, rd_addr_r <= count_r)
  `NPHT_ASSERT_NOW(a_best_in_radius, found_r, best_dist_r < 33'(limit_r))
  `NPHT_ASSERT_NOW(a_pipe_empty, state_r == S_RESP, !(v1_r || v2_r || v3_r || v4_r))
  `NPHT_ASSERT_NEXT(a_add_grows, wr_en, count_r == $past(count_r) + 1'b1)

endmodule
